/* design/ircl_pkg.sv */
package ircl_pkg;

  localparam int V4_TABLE_DEPTH_DEF = 65536;
  localparam int V6_TABLE_DEPTH_DEF = 16384;
  localparam int COUNTRY_BITS_DEF   = 8;

  localparam int KEY_W     = 128;
  localparam int V4_ADDR_W = 32;
  localparam int CFG_W     = 16;
  localparam int V6_LAST_W = 14;

  localparam logic [1:0] REQ_LOOKUP_V4 = 2'd0;
  localparam logic [1:0] REQ_LOOKUP_V6 = 2'd1;
  localparam logic [1:0] REQ_WRITE_V4  = 2'd2;
  localparam logic [1:0] REQ_WRITE_V6  = 2'd3;

  localparam logic CFG_V4_LAST = 1'b0;
  localparam logic CFG_V6_LAST = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] entry_index;
    logic [7:0]  entry_country;
  } in_item_t;

  typedef struct packed {
    logic [7:0] country_index;
    logic       found;
    logic       write_done;
  } out_item_t;

  typedef struct packed {
    logic below_mid;
    logic below_next;
  } cmp_res_t;

endpackage

/* design/ircl_table.sv */
module ircl_table
  import ircl_pkg::*;
#(
  parameter int DEPTH   = V4_TABLE_DEPTH_DEF,
  parameter int START_W = V4_ADDR_W,
  parameter int CTRY_W  = COUNTRY_BITS_DEF,
  localparam int IW     = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IW-1:0]      wr_addr,
  input  logic [START_W-1:0] wr_start,
  input  logic [CTRY_W-1:0]  wr_country,
  input  logic [IW-1:0]      rd_addr,
  output logic [START_W-1:0] mid_start,
  output logic [CTRY_W-1:0]  mid_country,
  output logic [START_W-1:0] next_start
);

  logic [START_W+CTRY_W-1:0] mem [DEPTH];
  logic [START_W+CTRY_W-1:0] rd_mid_r;
  logic [START_W+CTRY_W-1:0] rd_next_r;
  logic [IW-1:0]             rd_next_addr;

  assign rd_next_addr = rd_addr + IW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_start, wr_country};
    end
    rd_mid_r  <= mem[rd_addr];
    rd_next_r <= mem[rd_next_addr];
  end

  assign mid_start   = rd_mid_r[START_W+CTRY_W-1:CTRY_W];
  assign mid_country = rd_mid_r[CTRY_W-1:0];
  assign next_start  = rd_next_r[START_W+CTRY_W-1:CTRY_W];

endmodule

/* design/ircl_cmp.sv */
module ircl_cmp
  import ircl_pkg::*;
(
  input  logic [KEY_W-1:0] key,
  input  logic [KEY_W-1:0] mid_start,
  input  logic [KEY_W-1:0] next_start,
  output cmp_res_t         res
);

  assign res.below_mid  = key < mid_start;
  assign res.below_next = key < next_start;

endmodule

/* design/ip_range_country_lookup.sv */
// Range-table country lookup. A word is taken when start is high and busy is low.
// A table write's acknowledge appears in the cycle after the word is taken. A lookup
// is a binary search that probes one table position per cycle through a two-port
// read of the range table (the probed entry and the one after it) and one shared
// address comparator. Each result is shown on out_data for exactly one cycle with
// out_valid high and must be captured then, since the receiver cannot stall the
// block. Configuration is taken only while the block is idle, and the tables need
// no clearing after reset.
module ip_range_country_lookup
  import ircl_pkg::*;
#(
  parameter int V4_TABLE_DEPTH = V4_TABLE_DEPTH_DEF,
  parameter int V6_TABLE_DEPTH = V6_TABLE_DEPTH_DEF,
  parameter int COUNTRY_BITS   = COUNTRY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IW4  = $clog2(V4_TABLE_DEPTH);
  localparam int IW6  = $clog2(V6_TABLE_DEPTH);
  localparam int SW   = (IW4 > IW6) ? IW4 : IW6;
  localparam int BW   = SW + 1;
  localparam int SUMW = SW + 2;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic                  state_r, state_nxt;
  logic [CFG_W-1:0]      v4_last_r;
  logic [V6_LAST_W-1:0]  v6_last_r;
  logic [SW-1:0]         mid_r, mid_nxt;
  logic [SW-1:0]         last_r, last_nxt;
  logic [BW-1:0]         low_r, low_nxt;
  logic [BW-1:0]         high_r, high_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic                  is_v6_r, is_v6_nxt;
  logic                  all_ones_r, all_ones_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  accept;
  logic                  in_v6;
  logic                  in_all_ones;
  logic [SW-1:0]         last4, last6, last_sel;
  logic                  wr4_en, wr6_en;
  logic [COUNTRY_BITS-1:0] wr_country;

  logic [V4_ADDR_W-1:0]    v4_mid_start, v4_next_start;
  logic [COUNTRY_BITS-1:0] v4_mid_country;
  logic [KEY_W-1:0]        v6_mid_start, v6_next_start;
  logic [COUNTRY_BITS-1:0] v6_mid_country;
  logic [KEY_W-1:0]        cmp_mid, cmp_next;
  logic [COUNTRY_BITS-1:0] mid_country;
  cmp_res_t                cmp_res;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r == ST_SEARCH);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_v6       = (in_data.req_type == REQ_LOOKUP_V6);
  assign in_all_ones = in_v6 ? (&{in_data.addr_hi, in_data.addr_lo})
                             : (&in_data.addr_lo[V4_ADDR_W-1:0]);

  assign last4 = (32'(v4_last_r) >= 32'(V4_TABLE_DEPTH)) ? SW'(V4_TABLE_DEPTH - 1)
                                                        : SW'(v4_last_r);
  assign last6 = (32'(v6_last_r) >= 32'(V6_TABLE_DEPTH)) ? SW'(V6_TABLE_DEPTH - 1)
                                                        : SW'(v6_last_r);
  assign last_sel = in_v6 ? last6 : last4;

  assign wr_country = COUNTRY_BITS'(in_data.entry_country);
  assign wr4_en = accept && (in_data.req_type == REQ_WRITE_V4) &&
                  (32'(in_data.entry_index) < 32'(V4_TABLE_DEPTH));
  assign wr6_en = accept && (in_data.req_type == REQ_WRITE_V6) &&
                  (32'(in_data.entry_index) < 32'(V6_TABLE_DEPTH));

  ircl_table #(
    .DEPTH   (V4_TABLE_DEPTH),
    .START_W (V4_ADDR_W),
    .CTRY_W  (COUNTRY_BITS)
  ) u_v4_table (
    .clk         (clk),
    .wr_en       (wr4_en),
    .wr_addr     (IW4'(in_data.entry_index)),
    .wr_start    (in_data.addr_lo[V4_ADDR_W-1:0]),
    .wr_country  (wr_country),
    .rd_addr     (IW4'(mid_nxt)),
    .mid_start   (v4_mid_start),
    .mid_country (v4_mid_country),
    .next_start  (v4_next_start)
  );

  ircl_table #(
    .DEPTH   (V6_TABLE_DEPTH),
    .START_W (KEY_W),
    .CTRY_W  (COUNTRY_BITS)
  ) u_v6_table (
    .clk         (clk),
    .wr_en       (wr6_en),
    .wr_addr     (IW6'(in_data.entry_index)),
    .wr_start    ({in_data.addr_hi, in_data.addr_lo}),
    .wr_country  (wr_country),
    .rd_addr     (IW6'(mid_nxt)),
    .mid_start   (v6_mid_start),
    .mid_country (v6_mid_country),
    .next_start  (v6_next_start)
  );

  assign cmp_mid     = is_v6_r ? v6_mid_start  : KEY_W'(v4_mid_start);
  assign cmp_next    = is_v6_r ? v6_next_start : KEY_W'(v4_next_start);
  assign mid_country = is_v6_r ? v6_mid_country : v4_mid_country;

  ircl_cmp u_cmp (
    .key        (key_r),
    .mid_start  (cmp_mid),
    .next_start (cmp_next),
    .res        (cmp_res)
  );

  always_comb begin
    logic          finish;
    logic          hit;
    logic          cont;
    logic [BW-1:0] lo_t;
    logic [BW-1:0] hi_t;
    logic [SUMW-1:0] sum_t;

    state_nxt     = state_r;
    mid_nxt       = mid_r;
    last_nxt      = last_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    key_nxt       = key_r;
    is_v6_nxt     = is_v6_r;
    all_ones_nxt  = all_ones_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    finish        = 1'b0;
    hit           = 1'b0;
    cont          = 1'b0;
    lo_t          = low_r;
    hi_t          = high_r;
    sum_t         = '0;

    case (state_r)
      ST_IDLE: begin
        mid_nxt = in_all_ones ? last_sel : SW'(last_sel >> 1);
        if (accept) begin
          if (in_data.req_type == REQ_WRITE_V4 || in_data.req_type == REQ_WRITE_V6) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.country_index = '0;
            out_data_nxt.found         = 1'b0;
            out_data_nxt.write_done    = wr4_en || wr6_en;
          end else begin
            state_nxt    = ST_SEARCH;
            last_nxt     = last_sel;
            low_nxt      = '0;
            high_nxt     = BW'(last_sel);
            is_v6_nxt    = in_v6;
            all_ones_nxt = in_all_ones;
            key_nxt      = in_v6 ? {in_data.addr_hi, in_data.addr_lo}
                                 : KEY_W'(in_data.addr_lo[V4_ADDR_W-1:0]);
          end
        end
      end
      ST_SEARCH: begin
        if (all_ones_r) begin
          finish = 1'b1;
          hit    = 1'b1;
        end else if (cmp_res.below_mid) begin
          if (mid_r == '0) begin
            finish = 1'b1;
          end else begin
            hi_t = BW'(mid_r) - BW'(1);
            cont = 1'b1;
          end
        end else if (mid_r == last_r || cmp_res.below_next) begin
          finish = 1'b1;
          hit    = 1'b1;
        end else begin
          lo_t = BW'(mid_r) + BW'(1);
          cont = 1'b1;
        end
        if (cont) begin
          if (lo_t > hi_t) begin
            finish = 1'b1;
          end else begin
            sum_t    = SUMW'(lo_t) + SUMW'(hi_t);
            mid_nxt  = sum_t[SW:1];
            low_nxt  = lo_t;
            high_nxt = hi_t;
          end
        end
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt.country_index = hit ? 8'(mid_country) : 8'd0;
          out_data_nxt.found         = hit;
          out_data_nxt.write_done    = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v4_last_r   <= '0;
      v6_last_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_V4_LAST: v4_last_r <= cfg_data;
          CFG_V6_LAST: v6_last_r <= cfg_data[V6_LAST_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mid_r      <= mid_nxt;
    last_r     <= last_nxt;
    low_r      <= low_nxt;
    high_r     <= high_nxt;
    key_r      <= key_nxt;
    is_v6_r    <= is_v6_nxt;
    all_ones_r <= all_ones_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* tb/ip_range_country_lookup_tb.sv */
module ip_range_country_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ircl_pkg::*;

  localparam int WORDS_PER_PHASE = 169;
  localparam int PHASES = 6;
  localparam int LOAD_DEPTH = 256;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  localparam out_item_t BLANK = '0;
  localparam out_item_t ACKED = '{country_index: 8'h00, found: 1'b0, write_done: 1'b1};

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    in_item_t  word;
    logic      reg_idx;
    logic [CFG_W-1:0] reg_val;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_data;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  logic [31:0]  v4_start_tbl   [V4_TABLE_DEPTH_DEF];
  logic [7:0]   v4_country_tbl [V4_TABLE_DEPTH_DEF];
  logic [127:0] v6_start_tbl   [V6_TABLE_DEPTH_DEF];
  logic [7:0]   v6_country_tbl [V6_TABLE_DEPTH_DEF];
  logic [15:0]  v4_last;
  logic [13:0]  v6_last;

  out_item_t expected_q[$];
  plan_row_t directed_plan[$];
  int        err_count;
  int        stall_cycles;

  ip_range_country_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [127:0] start_at(input bit v6, input int unsigned slot);
    return v6 ? v6_start_tbl[slot] : {96'b0, v4_start_tbl[slot]};
  endfunction

  function automatic logic [7:0] country_at(input bit v6, input int unsigned slot);
    return v6 ? v6_country_tbl[slot] : v4_country_tbl[slot];
  endfunction

  function automatic out_item_t predict_country(input in_item_t w);
    out_item_t    r;
    bit           v6;
    logic [127:0] key;
    int unsigned  last;
    int unsigned  lo_i;
    int unsigned  hi_i;
    int unsigned  mid;
    r = BLANK;
    case (w.req_type)
      REQ_LOOKUP_V4, REQ_LOOKUP_V6: begin
        v6 = (w.req_type == REQ_LOOKUP_V6);
        key = v6 ? {w.addr_hi, w.addr_lo} : {96'b0, w.addr_lo[31:0]};
        last = v6 ? v6_last : v4_last;
        if (v6 ? (key == '1) : (w.addr_lo[31:0] == 32'hFFFF_FFFF)) begin
          r.country_index = country_at(v6, last);
          r.found = 1'b1;
        end else begin
          lo_i = 0;
          hi_i = last;
          while (lo_i <= hi_i) begin
            mid = (lo_i + hi_i) / 2;
            if (key < start_at(v6, mid)) begin
              if (mid == 0) break;
              hi_i = mid - 1;
            end else if (mid == last || key < start_at(v6, mid + 1)) begin
              r.country_index = country_at(v6, mid);
              r.found = 1'b1;
              break;
            end else begin
              lo_i = mid + 1;
            end
          end
        end
      end
      REQ_WRITE_V4: begin
        v4_start_tbl[w.entry_index] = w.addr_lo[31:0];
        v4_country_tbl[w.entry_index] = w.entry_country;
        r.write_done = 1'b1;
      end
      default: begin
        if (w.entry_index < V6_TABLE_DEPTH_DEF) begin
          v6_start_tbl[w.entry_index] = {w.addr_hi, w.addr_lo};
          v6_country_tbl[w.entry_index] = w.entry_country;
          r.write_done = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t noise_word();
    in_item_t w;
    w.req_type = 2'($urandom);
    w.addr_hi = {$urandom, $urandom};
    w.addr_lo = {$urandom, $urandom};
    w.entry_index = 16'($urandom);
    w.entry_country = 8'($urandom);
    return w;
  endfunction

  function automatic in_item_t make_lookup(input bit v6);
    in_item_t     w;
    logic [127:0] key;
    int           pick;
    w = noise_word();
    w.req_type = v6 ? REQ_LOOKUP_V6 : REQ_LOOKUP_V4;
    key = start_at(v6, $urandom_range(0, v6 ? v6_last : v4_last));
    pick = $urandom_range(0, 99);
    if (pick < 10) key = '1;
    else if (pick < 15) key = '0;
    else if (pick < 30) key = {w.addr_hi, w.addr_lo};
    else if (pick < 45) key = key - 1;
    else if (pick < 60) key = key + 1;
    else if (pick < 75) key = key + $urandom_range(0, 4096);
    if (v6) {w.addr_hi, w.addr_lo} = key;
    else w.addr_lo[31:0] = key[31:0];
    return w;
  endfunction

  function automatic in_item_t make_write(input bit v6);
    in_item_t    w;
    int unsigned lim;
    w = noise_word();
    w.req_type = v6 ? REQ_WRITE_V6 : REQ_WRITE_V4;
    lim = (v6 ? v6_last : v4_last) + 4;
    if (v6 && lim > V6_TABLE_DEPTH_DEF - 1) lim = V6_TABLE_DEPTH_DEF - 1;
    if (!v6 && lim > V4_TABLE_DEPTH_DEF - 1) lim = V4_TABLE_DEPTH_DEF - 1;
    if ($urandom_range(0, 99) >= 20) w.entry_index = 16'($urandom_range(0, lim));
    if ($urandom_range(0, 99) < 65) begin
      if (!v6) w.addr_lo[31:0] = v4_start_tbl[w.entry_index];
      else if (w.entry_index < V6_TABLE_DEPTH_DEF)
        {w.addr_hi, w.addr_lo} = v6_start_tbl[w.entry_index];
    end
    return w;
  endfunction

  function automatic void plan_word(input logic [1:0] req, input logic [63:0] hi,
                                    input logic [63:0] lo, input logic [15:0] idx,
                                    input logic [7:0] cty, input bit typed,
                                    input out_item_t want);
    plan_row_t row;
    row.kind = ROW_WORD;
    row.word = '{req_type: req, addr_hi: hi, addr_lo: lo, entry_index: idx,
                 entry_country: cty};
    row.reg_idx = CFG_V4_LAST;
    row.reg_val = '0;
    row.typed = typed;
    row.want = want;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_reg(input logic idx, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row.kind = ROW_REG;
    row.word = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    row.typed = 1'b0;
    row.want = BLANK;
    directed_plan.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 100) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Entered and left at a falling edge; start stays high for a following word.
  task automatic send_word(input in_item_t w, input int gap_pct, input bit typed,
                           input out_item_t want);
    out_item_t pred;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pred = predict_country(w);
    expected_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == CFG_V4_LAST) v4_last = val;
    else v6_last = val[13:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_q.pop_front();
        if (out_data.country_index !== want.country_index)
          report_mismatch($sformatf("country_index %0h, expected %0h",
                                    out_data.country_index, want.country_index));
        if (out_data.found !== want.found)
          report_mismatch($sformatf("found %b, expected %b", out_data.found, want.found));
        if (out_data.write_done !== want.write_done)
          report_mismatch($sformatf("write_done %b, expected %b",
                                    out_data.write_done, want.write_done));
      end
    end
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ip_range_country_lookup_tb: done, errors");
      $finish;
    end
  end

  initial begin : main
    logic [CFG_W-1:0] v4_set  [PHASES];
    logic [CFG_W-1:0] v6_set  [PHASES];
    int               gap_set [PHASES];
    in_item_t         w;
    int               i;
    int               p;
    int               pick;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_V4_LAST;
    cfg_data = '0;
    v4_last = '0;
    v6_last = '0;
    err_count = 0;
    stall_cycles = 0;
    foreach (v4_start_tbl[k]) begin
      v4_start_tbl[k] = '0;
      v4_country_tbl[k] = '0;
    end
    foreach (v6_start_tbl[k]) begin
      v6_start_tbl[k] = '0;
      v6_country_tbl[k] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Only slot 0 is live after reset, so each table starts with one range.
    plan_word(REQ_WRITE_V4, '1, 64'hFFFF_FFFF_0A00_0000, 16'd0, 8'h11, 1, ACKED);
    plan_word(REQ_WRITE_V6, 64'h2001_0000_0000_0000, '0, 16'd0, 8'h22, 1, ACKED);
    plan_word(REQ_LOOKUP_V4, '0, 64'h0000_0000_09FF_FFFF, '0, '0, 1, BLANK);
    plan_word(REQ_LOOKUP_V4, '0, 64'h0000_0000_0A00_0000, '0, '0, 1,
              out_item_t'{8'h11, 1'b1, 1'b0});
    plan_word(REQ_LOOKUP_V4, '1, 64'hFFFF_FFFF_FFFF_FFFE, '1, '1, 1,
              out_item_t'{8'h11, 1'b1, 1'b0});
    plan_word(REQ_LOOKUP_V4, '0, 64'h1234_5678_FFFF_FFFF, '0, '0, 1,
              out_item_t'{8'h11, 1'b1, 1'b0});
    plan_word(REQ_LOOKUP_V6, '0, '0, '0, '0, 1, BLANK);
    plan_word(REQ_LOOKUP_V6, '1, '1, '0, '0, 1, out_item_t'{8'h22, 1'b1, 1'b0});
    plan_word(REQ_LOOKUP_V6, '1, '0, '0, '0, 0, BLANK);
    plan_word(REQ_WRITE_V6, '0, '0, 16'd16384, 8'h5A, 1, BLANK);
    plan_word(REQ_WRITE_V6, '1, '1, 16'hFFFF, 8'hFF, 1, BLANK);
    plan_word(REQ_WRITE_V4, '0, '1, 16'hFFFF, 8'hFF, 1, ACKED);
    plan_word(REQ_WRITE_V4, '0, 64'h2000_0000, 16'd1, 8'h01, 1, ACKED);
    plan_word(REQ_WRITE_V4, '0, 64'h4000_0000, 16'd2, 8'h00, 1, ACKED);
    plan_word(REQ_WRITE_V4, '0, 64'h8000_0000, 16'd3, 8'h80, 1, ACKED);
    plan_word(REQ_WRITE_V6, 64'h3000_0000_0000_0000, '0, 16'd1, 8'h33, 1, ACKED);
    plan_word(REQ_WRITE_V6, 64'h4000_0000_0000_0000, '0, 16'd2, 8'h44, 1, ACKED);
    plan_word(REQ_WRITE_V6, '1, '0, 16'd3, 8'hFF, 1, ACKED);
    plan_reg(CFG_V4_LAST, 16'd3);
    plan_reg(CFG_V6_LAST, 16'hC003);
    plan_word(REQ_LOOKUP_V4, '0, 64'h3FFF_FFFF, '0, '0, 0, BLANK);
    plan_word(REQ_LOOKUP_V4, '0, 64'h8000_0000, '0, '0, 0, BLANK);
    plan_word(REQ_LOOKUP_V4, '0, '0, '0, '0, 1, BLANK);
    plan_word(REQ_LOOKUP_V6, 64'h3FFF_FFFF_FFFF_FFFF, '1, '0, '0, 0, BLANK);
    plan_word(REQ_LOOKUP_V6, '1, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, 0, BLANK);
    plan_word(REQ_LOOKUP_V6, '1, '1, '0, '0, 0, BLANK);
    plan_word(REQ_LOOKUP_V4, '0, 64'hFFFF_FFFF, '0, '0, 0, BLANK);

    foreach (directed_plan[k]) begin
      if (directed_plan[k].kind == ROW_REG)
        write_reg(directed_plan[k].reg_idx, directed_plan[k].reg_val);
      else
        send_word(directed_plan[k].word, 0, directed_plan[k].typed, directed_plan[k].want);
    end

    // Load the low slots of both tables in ascending order; every search stays inside them.
    for (i = 0; i < LOAD_DEPTH; i++) begin
      w = noise_word();
      w.req_type = REQ_WRITE_V4;
      w.entry_index = 16'(i);
      w.addr_lo = {$urandom, 16'(i), 16'($urandom) | 16'h0001};
      send_word(w, 0, 1'b0, BLANK);
    end
    for (i = 0; i < LOAD_DEPTH; i++) begin
      w = noise_word();
      w.req_type = REQ_WRITE_V6;
      w.entry_index = 16'(i);
      w.addr_hi = {14'(i), 18'($urandom), $urandom};
      send_word(w, 0, 1'b0, BLANK);
    end

    v4_set[0] = 16'(LOAD_DEPTH - 1);        v6_set[0] = 16'(LOAD_DEPTH - 1);
    gap_set[0] = 0;
    v4_set[1] = 16'd0;                      v6_set[1] = 16'd0;          gap_set[1] = 62;
    v4_set[2] = 16'd1;                      v6_set[2] = 16'd1;          gap_set[2] = 17;
    v4_set[3] = 16'($urandom_range(2, LOAD_DEPTH - 1));
    v6_set[3] = 16'($urandom_range(2, LOAD_DEPTH - 1));
    gap_set[3] = 62;
    v4_set[4] = 16'($urandom_range(0, LOAD_DEPTH - 1));
    v6_set[4] = 16'hC000 | 16'($urandom_range(0, LOAD_DEPTH - 1));
    gap_set[4] = 0;
    v4_set[5] = 16'(LOAD_DEPTH / 2);        v6_set[5] = 16'(LOAD_DEPTH / 2);
    gap_set[5] = 17;

    for (p = 0; p < PHASES; p++) begin
      write_reg(CFG_V4_LAST, v4_set[p]);
      write_reg(CFG_V6_LAST, v6_set[p]);
      for (i = 0; i < WORDS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) w = make_lookup(pick < 30);
        else w = make_write(pick < 80);
        send_word(w, gap_set[p], 1'b0, BLANK);
      end
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("ip_range_country_lookup_tb: done, clean");
    else
      $display("ip_range_country_lookup_tb: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
design/ircl_pkg.sv
design/ircl_table.sv
design/ircl_cmp.sv
design/ip_range_country_lookup.sv
tb/ip_range_country_lookup_tb.sv
